// ----- hw/rtl/kcl_pkg.sv -----
package kcl_pkg;

  localparam int CHAN_W = 2;
  localparam int KEY_W = 4;
  localparam int CODE_W = 24;
  localparam int TIME_W = 16;
  localparam int OUTC_W = 2;
  localparam int QDEPTH = 2;

  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_BACK = 4'd10;
  localparam logic [KEY_W-1:0] KEY_ENTER = 4'd11;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 16'd30000;

  localparam logic [OUTC_W-1:0] OUT_OK = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_WRONG = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_DISABLED = 2'd2;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_CODE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_DIGIT = 3'd1,
    CMD_BACK  = 3'd2,
    CMD_ENTER = 3'd3,
    CMD_TOUCH = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAN_W-1:0] chan;
    logic [KEY_W-1:0]  digit;
  } cmd_t;

  typedef struct packed {
    logic              enable;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic scanning;
    logic out_busy;
  } back_status_t;

endpackage

// ----- hw/rtl/kcl_ram.sv -----
module kcl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/kcl_front.sv -----
module kcl_front
  import kcl_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic [CHAN_W-1:0] chan,
  input  logic [KEY_W-1:0]  key,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic chan_ok;

  assign in_ready = !q_full;
  assign chan_ok = (32'(chan) < CHANNELS);
  // out-of-range channels are dropped here
  assign q_push = in_valid && in_ready && (op || chan_ok);

  always_comb begin
    q_cmd.chan = chan;
    q_cmd.digit = key;
    if (op) begin
      q_cmd.kind = CMD_TICK;
    end else if (key <= KEY_DIGIT_MAX) begin
      q_cmd.kind = CMD_DIGIT;
    end else if (key == KEY_BACK) begin
      q_cmd.kind = CMD_BACK;
    end else if (key == KEY_ENTER) begin
      q_cmd.kind = CMD_ENTER;
    end else begin
      q_cmd.kind = CMD_TOUCH;
    end
  end

endmodule

// ----- hw/rtl/kcl_cmd_fifo.sv -----
module kcl_cmd_fifo
  import kcl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] cnt_r;

  assign full = (cnt_r == CW'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign pop_cmd = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// ----- hw/rtl/kcl_back.sv -----
module kcl_back
  import kcl_pkg::*;
#(
  parameter int CHANNELS = 4,
  parameter int RING_LEN = 16,
  parameter int CODE_LEN = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  cmd_t         q_cmd,
  output logic         q_pop,
  input  cfg_t         cfg,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_data,
  output back_status_t status
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W = $clog2(RING_LEN);
  localparam int CNT_W = $clog2(RING_LEN + 1);
  localparam int DEPTH = CHANNELS * RING_LEN;
  localparam int AW = $clog2(DEPTH);
  localparam int WIN_W = 4 * CODE_LEN;
  localparam int SEEN_W = $clog2(CODE_LEN + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]  start_r [CHANNELS];
  logic [IDX_W-1:0]  start_nxt [CHANNELS];
  logic [IDX_W-1:0]  end_r [CHANNELS];
  logic [IDX_W-1:0]  end_nxt [CHANNELS];
  logic [CNT_W-1:0]  count_r [CHANNELS];
  logic [CNT_W-1:0]  count_nxt [CHANNELS];
  logic [TIME_W-1:0] idle_r [CHANNELS];
  logic [TIME_W-1:0] idle_nxt [CHANNELS];
  logic              run_r [CHANNELS];
  logic              run_nxt [CHANNELS];

  logic [CHAN_W-1:0] scan_chan_r, scan_chan_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic              pend_r, pend_nxt;
  logic [WIN_W-1:0]  win_r, win_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic              found_r, found_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0] res_chan_r, res_chan_nxt;
  logic [OUTC_W-1:0] res_outc_r, res_outc_nxt;
  logic              res_grant_r, res_grant_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [3:0]       rdata;
  logic [CH_W-1:0]  ch;
  logic [CH_W-1:0]  scan_ch;
  logic [WIN_W-1:0] code_vec;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_LEN - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(RING_LEN - 1) : i - 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_addr(input logic [CH_W-1:0] c,
                                              input logic [IDX_W-1:0] i);
    return AW'(int'(c) * RING_LEN + int'(i));
  endfunction

  assign ch = CH_W'(q_cmd.chan);
  assign scan_ch = CH_W'(scan_chan_r);
  assign code_vec = WIN_W'({8'd0, cfg.code});
  assign raddr = ring_addr(scan_ch, ptr_r);
  assign q_pop = (state_r == ST_IDLE) && q_valid &&
                 ((q_cmd.kind != CMD_ENTER) || !out_valid_r);

  kcl_ram #(
    .WIDTH(4),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(q_cmd.digit),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    end_nxt = end_r;
    count_nxt = count_r;
    idle_nxt = idle_r;
    run_nxt = run_r;
    scan_chan_nxt = scan_chan_r;
    ptr_nxt = ptr_r;
    remain_nxt = remain_r;
    pend_nxt = 1'b0;
    win_nxt = win_r;
    seen_nxt = seen_r;
    found_nxt = found_r;
    out_valid_nxt = out_valid_r;
    res_chan_nxt = res_chan_r;
    res_outc_nxt = res_outc_r;
    res_grant_nxt = res_grant_r;
    we = 1'b0;
    waddr = ring_addr(ch, end_r[ch]);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          if (q_cmd.kind != CMD_TICK) begin
            idle_nxt[ch] = cfg.timeout;
            run_nxt[ch] = 1'b1;
          end
          case (q_cmd.kind)
            CMD_TICK: begin
              for (int c = 0; c < CHANNELS; c++) begin
                if (run_r[c]) begin
                  if (idle_r[c] == '0) begin
                    start_nxt[c] = '0;
                    end_nxt[c] = '0;
                    count_nxt[c] = '0;
                    run_nxt[c] = 1'b0;
                  end else begin
                    idle_nxt[c] = idle_r[c] - 1'b1;
                  end
                end
              end
            end
            CMD_DIGIT: begin
              we = 1'b1;
              end_nxt[ch] = ring_inc(end_r[ch]);
              if (count_r[ch] < CNT_W'(RING_LEN)) begin
                count_nxt[ch] = count_r[ch] + 1'b1;
              end else begin
                start_nxt[ch] = ring_inc(end_r[ch]);
              end
            end
            CMD_BACK: begin
              if (count_r[ch] != '0) begin
                end_nxt[ch] = ring_dec(end_r[ch]);
                count_nxt[ch] = count_r[ch] - 1'b1;
              end
            end
            CMD_ENTER: begin
              if (!cfg.enable) begin
                out_valid_nxt = 1'b1;
                res_chan_nxt = q_cmd.chan;
                res_outc_nxt = OUT_DISABLED;
                res_grant_nxt = 1'b0;
              end else begin
                scan_chan_nxt = q_cmd.chan;
                ptr_nxt = start_r[ch];
                remain_nxt = count_r[ch];
                seen_nxt = '0;
                found_nxt = 1'b0;
                state_nxt = ST_SCAN;
              end
            end
            CMD_TOUCH: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (remain_r != '0) begin
          ptr_nxt = ring_inc(ptr_r);
          remain_nxt = remain_r - 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          win_nxt = WIN_W'({win_r, rdata});
          seen_nxt = (seen_r == SEEN_W'(CODE_LEN)) ? seen_r : seen_r + 1'b1;
          if ((seen_nxt == SEEN_W'(CODE_LEN)) && (win_nxt == code_vec)) begin
            found_nxt = 1'b1;
          end
        end
        if ((remain_r == '0) && !pend_r) begin
          out_valid_nxt = 1'b1;
          res_chan_nxt = scan_chan_r;
          res_outc_nxt = found_r ? OUT_OK : OUT_WRONG;
          res_grant_nxt = found_r;
          start_nxt[scan_ch] = '0;
          end_nxt[scan_ch] = '0;
          count_nxt[scan_ch] = '0;
          idle_nxt[scan_ch] = '0;
          run_nxt[scan_ch] = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        start_r[c] <= '0;
        end_r[c] <= '0;
        count_r[c] <= '0;
        idle_r[c] <= '0;
        run_r[c] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      start_r <= start_nxt;
      end_r <= end_nxt;
      count_r <= count_nxt;
      idle_r <= idle_nxt;
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_chan_r <= scan_chan_nxt;
    ptr_r <= ptr_nxt;
    remain_r <= remain_nxt;
    win_r <= win_nxt;
    seen_r <= seen_nxt;
    found_r <= found_nxt;
    res_chan_r <= res_chan_nxt;
    res_outc_r <= res_outc_nxt;
    res_grant_r <= res_grant_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = {3'b000, res_grant_r, res_outc_r, res_chan_r};
  assign status.scanning = (state_r == ST_SCAN);
  assign status.out_busy = out_valid_r;

endmodule

// ----- hw/rtl/keypad_code_lock.sv -----
// Multi-channel keypad code lock. Key presses and timer ticks enter on the
// in_ stream and are queued (two deep) ahead of the executing back end, so
// input keeps flowing while a result waits on out_. A digit, backspace, tick
// or other key is handled as it is taken from the queue; enter with the
// door enabled walks the channel's stored digits oldest first through the
// single read port of the digit memory, then reports granted or wrong code
// and clears the channel. With the door disabled enter reports disabled at
// once and keeps the digits. Only entries inside a channel's stored window,
// each written by a digit since the channel was last cleared, are ever read,
// so the digit memory needs no clearing after reset. Configuration is APB at
// byte addresses 0 (door_enable), 4 (door_code) and 8 (idle_timeout).
module keypad_code_lock
  import kcl_pkg::*;
#(
  parameter int CHANNELS = 4,
  parameter int RING_LEN = 16,
  parameter int CODE_LEN = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // channel[1:0], key[5:2], zero[7:6]
  input  logic        in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // result_channel[1:0], outcome[3:2], grant[4], zero[7:5]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t         cfg_r;
  logic         cfg_wr;
  logic [1:0]   cfg_idx;
  logic         q_full;
  logic         q_push;
  cmd_t         q_push_cmd;
  logic         q_valid;
  logic         q_pop;
  cmd_t         q_pop_cmd;
  back_status_t back_st;

  assign cfg_pready = 1'b1;
  assign cfg_idx = cfg_paddr[3:2];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b0;
      cfg_r.code <= '0;
      cfg_r.timeout <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLE:  cfg_r.enable <= cfg_pwdata[0];
        REG_CODE:    cfg_r.code <= cfg_pwdata[CODE_W-1:0];
        REG_TIMEOUT: cfg_r.timeout <= cfg_pwdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENABLE:  cfg_prdata = {31'd0, cfg_r.enable};
      REG_CODE:    cfg_prdata = {8'd0, cfg_r.code};
      REG_TIMEOUT: cfg_prdata = {16'd0, cfg_r.timeout};
      default:     cfg_prdata = '0;
    endcase
  end

  kcl_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .op      (in_tuser),
    .chan    (in_tdata[1:0]),
    .key     (in_tdata[5:2]),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_push_cmd)
  );

  kcl_cmd_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_cmd (q_pop_cmd)
  );

  kcl_back #(
    .CHANNELS(CHANNELS),
    .RING_LEN(RING_LEN),
    .CODE_LEN(CODE_LEN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_pop_cmd),
    .q_pop    (q_pop),
    .cfg      (cfg_r),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata),
    .status   (back_st)
  );

`ifndef SYNTH
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_scan_output_free: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.scanning |-> !back_st.out_busy)
    else $error("code search running while a result is pending");

  a_grant_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4] == (out_tdata[3:2] == OUT_OK)))
    else $error("grant disagrees with outcome");
`endif

endmodule
